/* sv/pas_pkg.sv */
// ============================================================================
// pas_pkg
// Shared widths, constants and pixel arithmetic for the 2x pixel-art scaler.
// ============================================================================
`default_nettype none

package pas_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned LW_W    = 11;
    localparam int unsigned FH_W    = 13;
    localparam int unsigned BCOL_W  = 10;
    localparam int unsigned BROW_W  = 12;
    localparam int unsigned CFG_W   = 13;

    localparam logic [10:0] REG_LINE_WIDTH   = 11'd0;
    localparam logic [10:0] REG_FRAME_HEIGHT = 11'd1;

    localparam logic [31:0] MASK_HI1 = 32'hFEFEFEFE;
    localparam logic [31:0] MASK_LO1 = 32'h01010101;
    localparam logic [31:0] MASK_HI2 = 32'hFCFCFCFC;
    localparam logic [31:0] MASK_LO2 = 32'h03030303;

    localparam logic [10:0] LW_RESET = 11'd640;
    localparam logic [12:0] FH_RESET = 13'd480;

    typedef logic [31:0] pixel_t;

    // Two-pixel per-channel floor average.
    function automatic pixel_t avg2(input pixel_t a, input pixel_t b);
        pixel_t r;
        r = ((a & MASK_HI1) >> 1) + ((b & MASK_HI1) >> 1) + (a & b & MASK_LO1);
        return (a == b) ? a : r;
    endfunction

    // Four-pixel per-channel floor average.
    function automatic pixel_t avg4(input pixel_t a, input pixel_t b,
                                    input pixel_t c, input pixel_t d);
        pixel_t hi;
        pixel_t lo;
        hi = ((a & MASK_HI2) >> 2) + ((b & MASK_HI2) >> 2)
           + ((c & MASK_HI2) >> 2) + ((d & MASK_HI2) >> 2);
        lo = (a & MASK_LO2) + (b & MASK_LO2) + (c & MASK_LO2) + (d & MASK_LO2);
        return hi + ((lo >> 2) & MASK_LO2);
    endfunction

    // Vote of one neighbour pair: +1, 0 or -1. Four votes sum to -4..+4,
    // so the result is four bits wide.
    function automatic logic signed [3:0] vote(input pixel_t a, input pixel_t b,
                                               input pixel_t p, input pixel_t q);
        logic na;
        logic nb;
        na = !((a == p) && (a == q));
        nb = !((b == p) && (b == q));
        return $signed({3'b000, na}) - $signed({3'b000, nb});
    endfunction

    typedef struct packed {
        logic   valid;
        logic   last;
        logic [BCOL_W-1:0] col;
        logic [BROW_W-1:0] row;
    } pas_tag_t;

endpackage

`default_nettype wire

/* sv/pixel_art_2x_upscaler.sv */
// ============================================================================
// pixel_art_2x_upscaler
// Streaming 2xSaI scaler: one source pixel in, at most one 2x2 block out.
// ============================================================================
//
//  channel | direction | payload                                    | flow
//  --------+-----------+--------------------------------------------+------------
//  in      | input     | pixel, start_frame                         | valid/stall
//  out     | output    | top_left..bottom_right, block_col/row, last| valid/stall
//  cfg     | input     | cfg_we, cfg_index, cfg_data                | write only
//
// One item per clock is sustained while the output is not stalled. The pipeline is three stages deep: the
// position stage issues line-store reads, the window stage shifts the 4x4
// window with the read data, and the kernel register holds the result. The
// whole pipeline advances together whenever the output register is free or
// being taken, so an item is accepted in the same cycle a finished result is
// delivered. Reset clears the position, the window and all valid bits; the
// line store needs no clearing.
// ============================================================================
`default_nettype none

module pixel_art_2x_upscaler #(
    parameter int unsigned MAX_WIDTH  = pas_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = pas_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [10:0]                 cfg_index,
    input  wire logic [pas_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [31:0]                 pixel,
    input  wire logic                        start_frame,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [31:0]                      top_left,
    output logic [31:0]                      top_right,
    output logic [31:0]                      bottom_left,
    output logic [31:0]                      bottom_right,
    output logic [pas_pkg::BCOL_W-1:0]       block_col,
    output logic [pas_pkg::BROW_W-1:0]       block_row,
    output logic                             last_block
);

    localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [10:0] lw_reg;
    logic [12:0] fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg <= pas_pkg::LW_RESET;
            fh_reg <= pas_pkg::FH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pas_pkg::REG_LINE_WIDTH)
                lw_reg <= cfg_data[10:0];
            else if (cfg_index == pas_pkg::REG_FRAME_HEIGHT)
                fh_reg <= cfg_data;
        end
    end

    // Effective (clamped) frame size.
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    always_comb
    begin
        if (32'(lw_reg) < 32'd4)              w_eff = XW'(4);
        else if (32'(lw_reg) > MAX_WIDTH)     w_eff = XW'(MAX_WIDTH);
        else                                  w_eff = XW'(lw_reg);
        if (32'(fh_reg) < 32'd4)              h_eff = YW'(4);
        else if (32'(fh_reg) > MAX_HEIGHT)    h_eff = YW'(MAX_HEIGHT);
        else                                  h_eff = YW'(fh_reg);
    end

    // Pipeline advance: everything moves when the output register is free or being taken.
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    logic acc;
    assign acc = in_valid && adv;

    // Position counters and the rotating line index (y mod 3).
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [1:0]    ph_reg;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [1:0]    ph;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_next;
    logic [1:0]    ph_next;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb
    begin
        x  = col_reg;
        y  = row_reg;
        ph = ph_reg;
        if (start_frame)
        begin
            x = '0; y = '0; ph = 2'd0;
        end
        else
        begin
            if (x >= w_eff)
            begin
                x = '0; y = y + 1'b1; ph = inc3(ph);
            end
            if (y >= h_eff)
            begin
                y = '0; ph = 2'd0;
            end
        end
        col_next = x + 1'b1;
        row_next = y;
        ph_next  = ph;
        if (col_next >= w_eff)
        begin
            col_next = '0;
            row_next = y + 1'b1;
            ph_next  = inc3(ph);
            if (row_next >= h_eff)
            begin
                row_next = '0;
                ph_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            ph_reg  <= 2'd0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            ph_reg  <= ph_next;
        end
    end

    // Line store access: the same column in the three line banks, with the
    // bank of the current line taking the new pixel.
    localparam int unsigned CW = $clog2(MAX_WIDTH);
    logic [CW-1:0] xc;
    logic [1:0]    p1;
    logic [1:0]    p2;
    assign xc = CW'(x);
    assign p1 = inc3(ph);
    assign p2 = inc3(p1);

    logic [31:0] r3;
    logic [31:0] r2;
    logic [31:0] r1;

    // Reads happen in the accept cycle; the memory only advances with an item,
    // so read data and the staged pixel stay paired across stalls.
    pas_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_store (
        .clk    (clk),
        .en     (acc),
        .col    (xc),
        .rsel0  (ph),
        .rsel1  (p1),
        .rsel2  (p2),
        .wsel   (ph),
        .wdata  (pixel),
        .rdata0 (r3),
        .rdata1 (r2),
        .rdata2 (r1)
    );

    // Stage 1: pixel and tag waiting for the read data.
    logic [31:0]       s1_pix_reg;
    pas_pkg::pas_tag_t s1_tag_reg;
    logic              s1_has_reg;
    pas_pkg::pas_tag_t tag;

    always_comb
    begin
        tag.valid = (x >= XW'(3)) && (y >= YW'(3));
        tag.last  = (x == w_eff - 1'b1) && (y == h_eff - 1'b1);
        tag.col   = pas_pkg::BCOL_W'(x - XW'(2));
        tag.row   = pas_pkg::BROW_W'(y - YW'(2));
    end

    // Stage 1 is consumed at the next advance, when the read data is
    // still held by the store's output registers (they move only on accept).
    // Shifting the window on that advance keeps data paired.
    pas_pkg::pixel_t win_reg [16];
    pas_pkg::pas_tag_t s2_tag_reg;
    logic              adv2;

    assign adv2 = adv && s1_has_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_has_reg <= 1'b0;
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            for (int k = 0; k < 16; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            if (adv2)
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 3; c++)
                        win_reg[r*4+c] <= win_reg[r*4+c+1];
                win_reg[3]  <= r3;
                win_reg[7]  <= r2;
                win_reg[11] <= r1;
                win_reg[15] <= s1_pix_reg;
                s2_tag_reg  <= s1_tag_reg;
            end
            else if (adv)
            begin
                s2_tag_reg.valid <= 1'b0;
            end
            if (adv)
            begin
                s1_has_reg <= acc;
                if (acc)
                    s1_tag_reg <= tag;
            end
        end
    end

    // The store output must not move between the read and its use in the
    // window shift: reads are enabled only on accept, and stage 1 drains on
    // the very next advance, which happens before or with the next accept.
    always_ff @(posedge clk)
    begin
        if (acc)
            s1_pix_reg <= pixel;
    end

    // Stage 3: kernel register and output tag.
    logic                 out_valid_reg;
    pas_pkg::pas_tag_t    o_tag_reg;

    pas_kernel u_kernel (
        .clk (clk),
        .en  (adv),
        .win (win_reg),
        .q0  (top_left),
        .q1  (top_right),
        .q2  (bottom_left),
        .q3  (bottom_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            o_tag_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_tag_reg.valid;
            o_tag_reg     <= s2_tag_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_col  = o_tag_reg.col;
    assign block_row  = o_tag_reg.row;
    assign last_block = o_tag_reg.last;

endmodule

`default_nettype wire

/* sv/pas_line_store.sv */
// ============================================================================
// pas_line_store
// Three-line pixel memory: synchronous read and write.
// ============================================================================
`default_nettype none

module pas_line_store #(
    parameter int unsigned MAX_WIDTH = pas_pkg::MAX_WIDTH_DEF,
    parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [CW-1:0] col,
    input  wire logic [1:0]    rsel0,
    input  wire logic [1:0]    rsel1,
    input  wire logic [1:0]    rsel2,
    input  wire logic [1:0]    wsel,
    input  wire logic [31:0]   wdata,
    output logic [31:0]        rdata0,
    output logic [31:0]        rdata1,
    output logic [31:0]        rdata2
);

    // One bank per line; each bank sees one read and at most one write a cycle.
    logic [31:0] bank0 [MAX_WIDTH];
    logic [31:0] bank1 [MAX_WIDTH];
    logic [31:0] bank2 [MAX_WIDTH];

    // The three reads share one column and name three distinct banks;
    // rdata0 comes from the bank chosen by rsel0 and so on. The write goes
    // to the same column.
    logic [31:0] q0_reg;
    logic [31:0] q1_reg;
    logic [31:0] q2_reg;
    logic [1:0]  s0_reg;
    logic [1:0]  s1_reg;
    logic [1:0]  s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= bank0[col];
            q1_reg <= bank1[col];
            q2_reg <= bank2[col];
            s0_reg <= rsel0;
            s1_reg <= rsel1;
            s2_reg <= rsel2;
            if (wsel == 2'd0) bank0[col] <= wdata;
            if (wsel == 2'd1) bank1[col] <= wdata;
            if (wsel == 2'd2) bank2[col] <= wdata;
        end
    end

    function automatic logic [31:0] pick(input logic [1:0] s, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c);
        logic [31:0] r;
        case (s)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    assign rdata0 = pick(s0_reg, q0_reg, q1_reg, q2_reg);
    assign rdata1 = pick(s1_reg, q0_reg, q1_reg, q2_reg);
    assign rdata2 = pick(s2_reg, q0_reg, q1_reg, q2_reg);

endmodule

`default_nettype wire

/* sv/pas_kernel.sv */
// ============================================================================
// pas_kernel
// 2xSaI rules on a 4x4 window, producing one 2x2 block, one register stage.
// ============================================================================
`default_nettype none

module pas_kernel (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire pas_pkg::pixel_t     win [16],
    output pas_pkg::pixel_t          q0,
    output pas_pkg::pixel_t          q1,
    output pas_pkg::pixel_t          q2,
    output pas_pkg::pixel_t          q3
);

    pas_pkg::pixel_t i_, e_, f_, j_, g_, a_, b_, k_, h_, c_, d_, l_, m_, n_, o_;
    pas_pkg::pixel_t a1, a2, a3;
    pas_pkg::pixel_t ab, ac, abcd;
    logic signed [3:0] v;

    always_comb
    begin
        i_ = win[0];  e_ = win[1];  f_ = win[2];  j_ = win[3];
        g_ = win[4];  a_ = win[5];  b_ = win[6];  k_ = win[7];
        h_ = win[8];  c_ = win[9];  d_ = win[10]; l_ = win[11];
        m_ = win[12]; n_ = win[13]; o_ = win[14];
        ab   = pas_pkg::avg2(a_, b_);
        ac   = pas_pkg::avg2(a_, c_);
        abcd = pas_pkg::avg4(a_, b_, c_, d_);
        v = pas_pkg::vote(a_, b_, g_, e_) + pas_pkg::vote(a_, b_, k_, f_)
          + pas_pkg::vote(a_, b_, h_, n_) + pas_pkg::vote(a_, b_, l_, o_);
        if (a_ == d_ && b_ != c_)
        begin
            a1 = ((a_ == e_ && b_ == l_) ||
                  (a_ == c_ && a_ == f_ && b_ != e_ && b_ == j_)) ? a_ : ab;
            a2 = ((a_ == g_ && c_ == o_) ||
                  (a_ == b_ && a_ == h_ && g_ != c_ && c_ == m_)) ? a_ : ac;
            a3 = a_;
        end
        else if (b_ == c_ && a_ != d_)
        begin
            a1 = ((b_ == f_ && a_ == h_) ||
                  (b_ == e_ && b_ == d_ && a_ != f_ && a_ == i_)) ? b_ : ab;
            a2 = ((c_ == h_ && a_ == f_) ||
                  (c_ == g_ && c_ == d_ && a_ != h_ && a_ == i_)) ? c_ : ac;
            a3 = b_;
        end
        else if (a_ == d_ && b_ == c_)
        begin
            if (a_ == b_)
            begin
                a1 = a_; a2 = a_; a3 = a_;
            end
            else
            begin
                a1 = ab;
                a2 = ac;
                if (v > 0)      a3 = a_;
                else if (v < 0) a3 = b_;
                else            a3 = abcd;
            end
        end
        else
        begin
            a3 = abcd;
            if (a_ == c_ && a_ == f_ && b_ != e_ && b_ == j_)      a1 = a_;
            else if (b_ == e_ && b_ == d_ && a_ != f_ && a_ == i_) a1 = b_;
            else                                                   a1 = ab;
            if (a_ == b_ && a_ == h_ && g_ != c_ && c_ == m_)      a2 = a_;
            else if (c_ == g_ && c_ == d_ && a_ != h_ && a_ == i_) a2 = c_;
            else                                                   a2 = ac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0 <= a_;
            q1 <= a1;
            q2 <= a2;
            q3 <= a3;
        end
    end

endmodule

`default_nettype wire
